/* rtl/core/hbd_pkg.sv */
// Shared types, constants and the filter tap table of the heartbeat detector.
package hbd_pkg;

   localparam int HISTORY_DEPTH = 32;
   localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int RATE_DEPTH    = 4;
   localparam int RATE_IDX_W    = $clog2(RATE_DEPTH);
   localparam int RATE_SUM_W    = 8 + RATE_IDX_W;

   // Symmetric filter: pairs 0..10 plus the center tap 11, span of 22 samples.
   localparam int FIR_PAIRS     = 11;
   localparam int FIR_SPAN      = 22;
   localparam int TAP_IDX_W     = 4;
   localparam int TAP_W         = 13;
   localparam int FIR_ACC_W     = 32;
   localparam int FIR_SHIFT     = 15;

   localparam int DC_SHIFT      = 4;
   localparam int DC_Q          = 15;

   localparam int QUO_W         = 16;
   localparam logic [QUO_W-1:0] BPM_NUMERATOR = 16'd60000;
   localparam logic [QUO_W-1:0] BPM_SATURATE  = 16'hFFFF;
   localparam logic [QUO_W-1:0] RATE_MIN      = 16'd20;
   localparam logic [QUO_W-1:0] RATE_MAX      = 16'd255;

   localparam logic [15:0] HELD_PEAK_RESET   = 16'sd20;
   localparam logic [15:0] HELD_TROUGH_RESET = -16'sd20;

   localparam logic [15:0] MIN_SWING_RESET   = 16'd20;
   localparam logic [15:0] MAX_SWING_RESET   = 16'd1000;
   localparam logic [17:0] LOW_LEVEL_RESET   = 18'd3000;

   localparam int          CSR_ADDR_W    = 4;
   localparam logic [1:0]  REG_MIN_SWING = 2'd0;
   localparam logic [1:0]  REG_MAX_SWING = 2'd1;
   localparam logic [1:0]  REG_LOW_LEVEL = 2'd2;

   typedef struct packed {
      logic [17:0] ir_sample;
      logic [31:0] time_ms;
   } hbd_req_type;

   typedef struct packed {
      logic signed [15:0] filtered_ac;
      logic               beat;
      logic               rate_accepted;
      logic [15:0]        instant_bpm;
      logic [7:0]         average_bpm;
      logic               low_signal;
   } hbd_rsp_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] ac;
   } fir_status_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_status_type;

   function automatic logic [TAP_W-1:0] fir_tap(input logic [TAP_IDX_W-1:0] k);
      logic [TAP_W-1:0] t;
      unique case (k)
         4'd0:    t = 13'd172;
         4'd1:    t = 13'd321;
         4'd2:    t = 13'd579;
         4'd3:    t = 13'd927;
         4'd4:    t = 13'd1360;
         4'd5:    t = 13'd1858;
         4'd6:    t = 13'd2390;
         4'd7:    t = 13'd2916;
         4'd8:    t = 13'd3391;
         4'd9:    t = 13'd3768;
         4'd10:   t = 13'd4012;
         4'd11:   t = 13'd4096;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

/* rtl/core/hbd_fir_mac.sv */
// History memory and shared multiply-accumulate of the symmetric low-pass filter.
module hbd_fir_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [15:0]             din,
   output hbd_pkg::fir_status_type status
);
   import hbd_pkg::*;

   localparam logic [TAP_IDX_W-1:0] LAST_K = TAP_IDX_W'(FIR_PAIRS);

   logic [15:0]              mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] vld_ff;
   logic [HIST_IDX_W-1:0]    pos_ff;

   logic                     iss_v_ff;
   logic [TAP_IDX_W-1:0]     k_ff;
   logic                     rd_v_ff;
   logic [TAP_IDX_W-1:0]     rd_k_ff;
   logic [15:0]              rd_a_ff;
   logic [15:0]              rd_b_ff;
   logic                     rd_a_vld_ff;
   logic                     rd_b_vld_ff;
   logic                     pr_v_ff;
   logic                     pr_last_ff;
   logic [15:0]              pair_ff;
   logic [TAP_W-1:0]         tap_ff;
   logic                     mu_v_ff;
   logic                     mu_last_ff;
   logic signed [29:0]       prod_ff;
   logic signed [FIR_ACC_W-1:0] acc_ff;
   logic                     done_ff;

   logic [HIST_IDX_W-1:0]    addr_a;
   logic [HIST_IDX_W-1:0]    addr_b;
   logic [15:0]              opnd_a;
   logic [15:0]              opnd_b;

   // Pair k combines the sample k back with the one 22 - k back.
   assign addr_a = pos_ff - HIST_IDX_W'(k_ff);
   assign addr_b = pos_ff - HIST_IDX_W'(FIR_SPAN) + HIST_IDX_W'(k_ff);

   // Entries never written read as zero; the center tap has no partner.
   assign opnd_a = rd_a_vld_ff ? rd_a_ff : '0;
   assign opnd_b = (rd_b_vld_ff && (rd_k_ff != LAST_K)) ? rd_b_ff : '0;

   always_ff @(posedge clock) begin
      if (start) begin
         mem[pos_ff] <= din;
      end
      rd_a_ff     <= mem[addr_a];
      rd_b_ff     <= mem[addr_b];
      rd_a_vld_ff <= vld_ff[addr_a];
      rd_b_vld_ff <= vld_ff[addr_b];
      rd_k_ff     <= k_ff;
      pair_ff     <= opnd_a + opnd_b;
      tap_ff      <= fir_tap(rd_k_ff);
      pr_last_ff  <= (rd_k_ff == LAST_K);
      prod_ff     <= $signed(pair_ff) * $signed({1'b0, tap_ff});
      mu_last_ff  <= pr_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         pos_ff   <= '0;
         iss_v_ff <= 1'b0;
         k_ff     <= '0;
         rd_v_ff  <= 1'b0;
         pr_v_ff  <= 1'b0;
         mu_v_ff  <= 1'b0;
         acc_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         rd_v_ff <= iss_v_ff;
         pr_v_ff <= rd_v_ff;
         mu_v_ff <= pr_v_ff;
         done_ff <= mu_v_ff && mu_last_ff;
         if (start) begin
            vld_ff[pos_ff] <= 1'b1;
            iss_v_ff       <= 1'b1;
            k_ff           <= '0;
            acc_ff         <= '0;
         end else if (iss_v_ff) begin
            k_ff <= k_ff + 1'b1;
            if (k_ff == LAST_K) begin
               iss_v_ff <= 1'b0;
            end
         end
         if (mu_v_ff) begin
            acc_ff <= acc_ff + FIR_ACC_W'(prod_ff);
            if (mu_last_ff) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   assign status.done = done_ff;
   assign status.ac   = acc_ff[FIR_SHIFT+15:FIR_SHIFT];

endmodule

/* rtl/core/hbd_divider.sv */
// Serial restoring divider that forms the beat rate from the beat interval.
module hbd_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             divisor,
   output hbd_pkg::div_status_type status
);
   import hbd_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [QUO_W-1:0] num_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [31:0]      rem_ff;
   logic [31:0]      dvs_ff;

   logic [32:0]      rem_shift;
   logic             fits;
   logic [32:0]      rem_in;

   assign rem_shift = {rem_ff, num_ff[QUO_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};
   assign rem_in    = fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;

   always_ff @(posedge clock) begin
      if (start) begin
         dvs_ff <= divisor;
         num_ff <= BPM_NUMERATOR;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in[31:0];
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

/* rtl/core/ppg_heartbeat_detector_top.sv */
// Top level of the optical pulse heartbeat detector: control, trackers, rate ring and ports.
// One sample in, one result out. A sample without a beat passes through the DC tracker, the
// filter and peak and trough tracking, and is then loaded into the output register. The filter
// runs its 12 products (11 tap pairs and the center tap) through a single multiplier, reading
// two history entries per cycle from a 32-entry memory; the products are issued, then pass the
// read, pair and product stages, and the done flag follows. A beat at the same timestamp as the
// previous one skips the divider and goes straight to the rate check. Any other beat first
// waits on the serial divider, which forms the 60000/interval rate at one quotient bit per
// cycle, and then goes to the rate check. The average is refreshed when the rate goes into the
// ring. A new sample transfers only in the idle state, after the previous result is loaded, and
// a full output register holds the block until it drains. The user must write the swing bounds
// and the low-signal level over the APB port only while no sample is in flight; the block itself
// does not enforce it.
module ppg_heartbeat_detector_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  hbd_pkg::hbd_req_type         req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hbd_pkg::hbd_rsp_type         rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hbd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import hbd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DC     = 3'd1;
   localparam logic [2:0] ST_FIR    = 3'd2;
   localparam logic [2:0] ST_DETECT = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_RATE   = 3'd5;
   localparam logic [2:0] ST_AVG    = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]  state_ff, state_in;

   logic [15:0] min_swing_ff;
   logic [15:0] max_swing_ff;
   logic [17:0] low_level_ff;

   logic [17:0] sample_ff;
   logic [31:0] time_ff;

   logic [31:0]        dc_acc_ff, dc_acc_in;
   logic signed [15:0] ac_ff, ac_in;
   logic signed [15:0] run_peak_ff, run_peak_in;
   logic signed [15:0] run_trough_ff, run_trough_in;
   logic signed [15:0] held_peak_ff, held_peak_in;
   logic signed [15:0] held_trough_ff, held_trough_in;
   logic               rising_ff, rising_in;
   logic               falling_ff, falling_in;
   logic [31:0]        last_beat_ff, last_beat_in;
   logic               beat_ff, beat_in;
   logic               accepted_ff, accepted_in;
   logic [QUO_W-1:0]   bpm_ff, bpm_in;
   logic [15:0]        inst_bpm_ff, inst_bpm_in;
   logic [7:0]         avg_bpm_ff, avg_bpm_in;
   logic [7:0]         ring_ff [RATE_DEPTH];
   logic [RATE_IDX_W-1:0] ring_pos_ff, ring_pos_in;
   logic               ring_wr;

   logic               rsp_valid_ff, rsp_valid_in;
   hbd_rsp_type        rsp_ff;

   logic               fir_start;
   logic [15:0]        fir_din;
   fir_status_type     fir_st;
   logic               div_start;
   div_status_type     div_st;
   logic [31:0]        delta;

   logic               csr_wr;
   logic               slot_free;

   logic signed [33:0] dc_prev;
   logic signed [33:0] dc_target;
   logic signed [33:0] dc_diff;
   logic signed [33:0] dc_sum;
   logic [15:0]        dc_est;

   logic signed [16:0] swing;
   logic               cross_up;
   logic               cross_down;
   logic [RATE_SUM_W-1:0] ring_sum;

   hbd_fir_mac u_fir (
      .clock  (clock),
      .reset  (reset),
      .start  (fir_start),
      .din    (fir_din),
      .status (fir_st)
   );

   hbd_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (delta),
      .status  (div_st)
   );

   // Configuration registers.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_swing_ff <= MIN_SWING_RESET;
         max_swing_ff <= MAX_SWING_RESET;
         low_level_ff <= LOW_LEVEL_RESET;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_MIN_SWING: min_swing_ff <= pwdata[15:0];
            REG_MAX_SWING: max_swing_ff <= pwdata[15:0];
            REG_LOW_LEVEL: low_level_ff <= pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MIN_SWING: prdata = {16'd0, min_swing_ff};
         REG_MAX_SWING: prdata = {16'd0, max_swing_ff};
         REG_LOW_LEVEL: prdata = {14'd0, low_level_ff};
         default:       prdata = '0;
      endcase
   end

   // DC tracker: leaky accumulator in Q15 fed with the low 16 bits of the sample.
   assign dc_prev   = {{2{dc_acc_ff[31]}}, dc_acc_ff};
   assign dc_target = {3'd0, sample_ff[15:0], 15'd0};
   assign dc_diff   = dc_target - dc_prev;
   assign dc_sum    = dc_prev + (dc_diff >>> DC_SHIFT);
   assign dc_est    = dc_sum[DC_Q+15:DC_Q];
   assign fir_din   = sample_ff[15:0] - dc_est;
   assign fir_start = (state_ff == ST_DC);

   // Zero crossings of the filtered signal, and the swing held at a rising one.
   assign cross_up   = (ac_ff < 0) && (fir_st.ac >= 0);
   assign cross_down = (ac_ff > 0) && (fir_st.ac <= 0);
   assign swing      = {run_peak_ff[15], run_peak_ff} - {run_trough_ff[15], run_trough_ff};

   assign delta     = time_ff - last_beat_ff;
   assign div_start = (state_ff == ST_DETECT) && beat_in && (delta != '0);

   always_comb begin
      ring_sum = '0;
      for (int i = 0; i < RATE_DEPTH; i++) begin
         ring_sum = ring_sum + RATE_SUM_W'(ring_ff[i]);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      dc_acc_in      = dc_acc_ff;
      ac_in          = ac_ff;
      run_peak_in    = run_peak_ff;
      run_trough_in  = run_trough_ff;
      held_peak_in   = held_peak_ff;
      held_trough_in = held_trough_ff;
      rising_in      = rising_ff;
      falling_in     = falling_ff;
      last_beat_in   = last_beat_ff;
      beat_in        = beat_ff;
      accepted_in    = accepted_ff;
      bpm_in         = bpm_ff;
      inst_bpm_in    = inst_bpm_ff;
      avg_bpm_in     = avg_bpm_ff;
      ring_pos_in    = ring_pos_ff;
      ring_wr        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DC;
            end
         end
         ST_DC: begin
            dc_acc_in   = dc_sum[31:0];
            beat_in     = 1'b0;
            accepted_in = 1'b0;
            state_in    = ST_FIR;
         end
         ST_FIR: begin
            if (fir_st.done) begin
               state_in = ST_DETECT;
            end
         end
         ST_DETECT: begin
            ac_in = fir_st.ac;
            if (cross_up) begin
               held_peak_in   = run_peak_ff;
               held_trough_in = run_trough_ff;
               rising_in      = 1'b1;
               falling_in     = 1'b0;
               run_peak_in    = '0;
               beat_in = ($signed({swing[16], swing}) > $signed({2'b00, min_swing_ff})) &&
                         ($signed({swing[16], swing}) < $signed({2'b00, max_swing_ff}));
            end
            if (cross_down) begin
               rising_in     = 1'b0;
               falling_in    = 1'b1;
               run_trough_in = '0;
            end
            if (rising_in && (fir_st.ac > ac_ff)) begin
               run_peak_in = fir_st.ac;
            end
            if (falling_in && (fir_st.ac < ac_ff)) begin
               run_trough_in = fir_st.ac;
            end
            if (beat_in) begin
               last_beat_in = time_ff;
               if (delta == '0) begin
                  bpm_in   = BPM_SATURATE;
                  state_in = ST_RATE;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               bpm_in   = div_st.quotient;
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            inst_bpm_in = bpm_ff;
            if ((bpm_ff > RATE_MIN) && (bpm_ff < RATE_MAX)) begin
               ring_wr     = 1'b1;
               accepted_in = 1'b1;
               ring_pos_in = (ring_pos_ff == RATE_IDX_W'(RATE_DEPTH - 1)) ? '0 :
                             ring_pos_ff + 1'b1;
               state_in    = ST_AVG;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_AVG: begin
            avg_bpm_in = ring_sum[RATE_SUM_W-1:RATE_IDX_W];
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_payload.ir_sample;
         time_ff   <= req_payload.time_ms;
      end
      if ((state_ff == ST_OUT) && slot_free) begin
         rsp_ff.filtered_ac   <= ac_ff;
         rsp_ff.beat          <= beat_ff;
         rsp_ff.rate_accepted <= accepted_ff;
         rsp_ff.instant_bpm   <= inst_bpm_ff;
         rsp_ff.average_bpm   <= avg_bpm_ff;
         rsp_ff.low_signal    <= (sample_ff < low_level_ff);
      end
      bpm_ff <= bpm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         dc_acc_ff      <= '0;
         ac_ff          <= '0;
         run_peak_ff    <= '0;
         run_trough_ff  <= '0;
         held_peak_ff   <= HELD_PEAK_RESET;
         held_trough_ff <= HELD_TROUGH_RESET;
         rising_ff      <= 1'b0;
         falling_ff     <= 1'b0;
         last_beat_ff   <= '0;
         beat_ff        <= 1'b0;
         accepted_ff    <= 1'b0;
         inst_bpm_ff    <= '0;
         avg_bpm_ff     <= '0;
         ring_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < RATE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         dc_acc_ff      <= dc_acc_in;
         ac_ff          <= ac_in;
         run_peak_ff    <= run_peak_in;
         run_trough_ff  <= run_trough_in;
         held_peak_ff   <= held_peak_in;
         held_trough_ff <= held_trough_in;
         rising_ff      <= rising_in;
         falling_ff     <= falling_in;
         last_beat_ff   <= last_beat_in;
         beat_ff        <= beat_in;
         accepted_ff    <= accepted_in;
         inst_bpm_ff    <= inst_bpm_in;
         avg_bpm_ff     <= avg_bpm_in;
         ring_pos_ff    <= ring_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (ring_wr) begin
            ring_ff[ring_pos_ff] <= bpm_ff[7:0];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
